// ----- rtl/kcsf_pkg.sv -----
// package for the kempe chain swap finder: sizes, codes and state type
package kcsf_pkg;
    localparam int MaxTeachers = 64;
    localparam int MaxSlots    = 64;
    localparam int StudentBits = 8;

    localparam logic [1:0] FuncWrCell  = 2'd0;
    localparam logic [1:0] FuncWrAvail = 2'd1;
    localparam logic [1:0] FuncRun     = 2'd2;
    localparam logic [1:0] FuncNone    = 2'd3;

    localparam logic [6:0] TeachersReset = 7'd64;
    localparam logic [0:0] RegTeachers   = 1'b0;

    typedef enum logic [3:0] {
        t_idle_s   = 4'd0,
        t_chk0     = 4'd1,
        t_chk1     = 4'd2,
        t_chk2     = 4'd3,
        t_pop      = 4'd4,
        t_popw     = 4'd5,
        t_cella    = 4'd6,
        t_cellb    = 4'd7,
        t_scan     = 4'd8,
        t_emit     = 4'd9,
        t_rej      = 4'd10
    } t_state;
endpackage

// ----- rtl/kcsf_ram.sv -----
// generic single port ram with registered read
module kcsf_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // write or read one entry per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end
    assign o_rdata = r_rdata;
endmodule

// ----- rtl/kempe_chain_swap_finder.sv -----
// kempe chain swap finder top level: tables, walk queue and sequencer
//
// Requests enter on a valid/ready channel: func 0 writes a schedule cell,
// func 1 writes an availability bit, func 2 runs a chain from a teacher
// and two slots. A write gives no result, so writes can follow back to
// back. A run first reads the teacher's two cells and availability
// bits; a rejected move puts its one result (valid_res low, last high)
// on the output after the check states and the reject state.
// A passing move walks breadth first: each teacher taken from the queue
// costs one table read per row for each of its two slots, and the
// single-ported cell table reads one cell per cycle. Each chain entry
// goes into a one-deep output register; the walk waits while the
// receiver stalls, and the next request is taken only once the final
// result has left. After reset teachers_in_use is 64, the queue is
// empty and all visit marks are clear; the cell and availability
// tables hold nothing defined until written. Register teachers_in_use
// is at APB address 0.
module kempe_chain_swap_finder
    import kcsf_pkg::*;
#(
    parameter int MAX_TEACHERS = kcsf_pkg::MaxTeachers,
    parameter int MAX_SLOTS    = kcsf_pkg::MaxSlots,
    parameter int STUDENT_BITS = kcsf_pkg::StudentBits
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_func,
    input  logic [5:0]  i_teacher,
    input  logic [5:0]  i_slot_a,
    input  logic [5:0]  i_slot_b,
    input  logic [7:0]  i_student,
    input  logic        i_flag_bit,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_chain_teacher,
    output logic        o_valid_res,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int TB = $clog2(MAX_TEACHERS);
    localparam int SB = $clog2(MAX_SLOTS);
    localparam int AB = TB + SB;
    localparam int CW = STUDENT_BITS + 1;
    localparam int NB = $clog2(MAX_TEACHERS + 1);

    t_state r_state, n_state;
    logic [6:0]          r_tin;
    logic [TB-1:0]       r_t;
    logic [SB-1:0]       r_sa, r_sb;
    logic [CW-1:0]       r_ca;
    logic                r_ava;
    logic                r_phase;
    logic [TB-1:0]       r_u;
    logic [CW-1:0]       r_cu;
    logic [NB-1:0]       r_i, n_i;
    logic [NB-1:0]       r_head, r_tail;
    logic [MAX_TEACHERS-1:0] r_vis;
    logic                r_ov;
    logic [5:0]          r_ot;
    logic                r_ores, r_olast;
    logic                r_scanv;
    logic [TB-1:0]       r_scani;

    logic          cell_we, av_we, q_we;
    logic [AB-1:0] cell_addr;
    logic [CW-1:0] cell_wd, cell_rd;
    logic          av_rd;
    logic [TB-1:0] q_addr, q_wd, q_rd;
    logic [NB-1:0] n_eff;
    logic          in_fire, in_range, wr_fire;
    logic          hit;

    assign pready = 1'b1;
    assign prdata = {25'd0, r_tin};
    assign wr_fire = psel && penable && pwrite && (paddr[2] == RegTeachers);
    assign in_fire = i_valid && o_ready;
    assign o_ready = (r_state == t_idle_s) && !r_ov;
    assign n_eff = (r_tin > 7'(MAX_TEACHERS)) ? NB'(MAX_TEACHERS) : NB'(r_tin);
    assign in_range = (7'(i_teacher) < 7'(MAX_TEACHERS)) && (7'(i_slot_a) < 7'(MAX_SLOTS));

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tin <= TeachersReset;
        end else if (wr_fire) begin
            r_tin <= pwdata[6:0];
        end
    end

    kcsf_ram #(.Width(CW), .Depth(MAX_TEACHERS * MAX_SLOTS)) u_cells (
        .i_clk(i_clk), .i_we(cell_we), .i_addr(cell_addr),
        .i_wdata(cell_wd), .o_rdata(cell_rd)
    );
    kcsf_ram #(.Width(1), .Depth(MAX_TEACHERS * MAX_SLOTS)) u_avail (
        .i_clk(i_clk), .i_we(av_we), .i_addr(cell_addr),
        .i_wdata(i_flag_bit), .o_rdata(av_rd)
    );
    kcsf_ram #(.Width(TB), .Depth(MAX_TEACHERS)) u_queue (
        .i_clk(i_clk), .i_we(q_we), .i_addr(q_addr),
        .i_wdata(q_wd), .o_rdata(q_rd)
    );

    assign cell_wd = i_flag_bit ? {1'b1, i_student[STUDENT_BITS-1:0]} : '0;
    // match of the scanned row against the current cell
    assign hit = r_scanv && r_cu[CW-1] && (cell_rd == r_cu) && !r_vis[r_scani];

    // next state
    always_comb begin
        n_state = r_state;
        n_i = r_i;
        case (r_state)
            t_idle_s: begin
                if (in_fire && i_func == FuncRun) n_state = t_chk0;
            end
            t_chk0: n_state = t_chk1;
            t_chk1: n_state = t_chk2;
            t_chk2: begin
                if (7'(r_t) >= 7'(n_eff) || r_sa == r_sb || !r_ava || !av_rd
                    || r_ca == cell_rd) n_state = t_rej;
                else n_state = t_pop;
            end
            t_pop:   n_state = t_popw;
            t_popw:  n_state = t_cella;
            t_cella: n_state = t_cellb;
            t_cellb: begin
                n_state = t_scan;
                n_i = '0;
            end
            t_scan: begin
                if (r_i < n_eff) n_i = r_i + 1'b1;
                else if (!r_scanv) begin
                    if (!r_phase) begin
                        n_state = t_scan;
                        n_i = '0;
                    end else n_state = t_emit;
                end
            end
            t_emit: begin
                if (!r_ov) n_state = (r_head == r_tail) ? t_idle_s : t_pop;
            end
            t_rej: if (!r_ov) n_state = t_idle_s;
            default: n_state = t_idle_s;
        endcase
    end

    // memory controls
    always_comb begin
        cell_we = 1'b0;
        av_we = 1'b0;
        q_we = 1'b0;
        q_wd = r_t;
        q_addr = r_head[TB-1:0];
        cell_addr = {i_teacher[TB-1:0], i_slot_a[SB-1:0]};
        case (r_state)
            t_idle_s: begin
                cell_we = in_fire && i_func == FuncWrCell && in_range;
                av_we = in_fire && i_func == FuncWrAvail && in_range;
            end
            t_chk0: cell_addr = {r_t, r_sa};
            t_chk1: cell_addr = {r_t, r_sb};
            t_pop: begin
                q_addr = r_head[TB-1:0];
            end
            t_cella: cell_addr = {r_u, r_sa};
            t_cellb: cell_addr = {r_u, r_sb};
            t_scan: begin
                cell_addr = {r_i[TB-1:0], r_phase ? r_sa : r_sb};
                if (hit) begin
                    q_we = 1'b1;
                    q_addr = r_tail[TB-1:0];
                    q_wd = r_scani;
                end
            end
            default: ;
        endcase
        if (r_state == t_chk2 && n_state == t_pop) begin
            q_we = 1'b1;
            q_addr = '0;
            q_wd = r_t;
        end
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_idle_s;
            r_vis <= '0;
            r_head <= '0;
            r_tail <= '0;
            r_ov <= 1'b0;
            r_scanv <= 1'b0;
            r_phase <= 1'b0;
            r_i <= '0;
        end else begin
            r_state <= n_state;
            r_i <= n_i;
            if (r_ov && i_ready) r_ov <= 1'b0;
            case (r_state)
                t_idle_s: begin
                    r_t <= i_teacher[TB-1:0];
                    // a teacher or slot beyond the table forces equal slots so the check rejects
                    if (7'(i_slot_a) >= 7'(MAX_SLOTS) || 7'(i_slot_b) >= 7'(MAX_SLOTS)
                        || 7'(i_teacher) >= 7'(MAX_TEACHERS)) begin
                        r_sa <= '0;
                        r_sb <= '0;
                    end else begin
                        r_sa <= i_slot_a[SB-1:0];
                        r_sb <= i_slot_b[SB-1:0];
                    end
                    if (in_fire) r_ot <= i_teacher;
                end
                t_chk2: begin
                    r_vis <= {{(MAX_TEACHERS-1){1'b0}}, 1'b1} << r_t;
                    r_head <= '0;
                    r_tail <= NB'(1);
                end
                t_popw: begin
                    r_u <= q_rd;
                    r_head <= r_head + 1'b1;
                    r_phase <= 1'b0;
                end
                t_cellb: r_cu <= cell_rd;
                t_scan: begin
                    r_scanv <= (r_i < n_eff);
                    r_scani <= r_i[TB-1:0];
                    if (hit && r_tail < NB'(MAX_TEACHERS)) begin
                        r_vis[r_scani] <= 1'b1;
                        r_tail <= r_tail + 1'b1;
                    end
                    if (r_i >= n_eff && !r_scanv && !r_phase) begin
                        r_phase <= 1'b1;
                        r_cu <= r_ca;
                    end
                end
                t_emit: if (!r_ov) begin
                    r_ov <= 1'b1;
                    r_ot <= 6'(r_u);
                    r_ores <= 1'b1;
                    r_olast <= (r_head == r_tail);
                end
                t_rej: if (!r_ov) begin
                    r_ov <= 1'b1;
                    r_ores <= 1'b0;
                    r_olast <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // check-phase data capture and second-slot cell of the popped teacher
    always_ff @(posedge i_clk) begin
        case (r_state)
            t_chk1: begin
                r_ca <= cell_rd;
                r_ava <= av_rd;
            end
            t_cellb: ;
            t_scan: ;
            default: ;
        endcase
        if (r_state == t_scan && r_i == '0 && !r_phase && !r_scanv) r_ca <= cell_rd;
    end

    assign o_valid = r_ov;
    assign o_chain_teacher = r_ot;
    assign o_valid_res = r_ores;
    assign o_last = r_olast;
endmodule
